>>> sv/hrb_pkg.sv
// Shared types, codes and the keymap table for the HID report builder.
// No dependencies; imported by every module of the block.
package hrb_pkg;

  localparam int BODY_LEN    = 7;
  localparam int KEY_SLOTS   = 6;
  localparam int DEAD_KEYS   = 6;
  localparam int KEYMAP_ROWS = 128;

  // Bits of a looked-up keycode and the modifier bits they drive
  localparam int          SHIFT_POS  = 8;
  localparam int          ALTGR_POS  = 9;
  localparam logic [7:0]  MOD_LSHIFT = 8'h02;
  localparam logic [7:0]  MOD_RALT   = 8'h40;
  localparam logic [9:0]  SH         = 10'h100;

  typedef enum logic [3:0] {
    KIND_CHAR           = 4'd0,
    KIND_SPECIAL        = 4'd1,
    KIND_MODIFIER       = 4'd2,
    KIND_MEDIA          = 4'd3,
    KIND_MBUTTON        = 4'd4,
    KIND_MWHEEL         = 4'd5,
    KIND_MMOVE          = 4'd6,
    KIND_DEAD_GRAVE     = 4'd7,
    KIND_DEAD_ACUTE     = 4'd8,
    KIND_DEAD_CIRCUMFLEX = 4'd9,
    KIND_DEAD_TILDE     = 4'd10,
    KIND_DEAD_DIAERESIS = 4'd11,
    KIND_DEAD_CEDILLA   = 4'd12
  } key_kind_e;

  typedef enum logic [1:0] {
    RPT_KEYBOARD = 2'd0,
    RPT_MEDIA    = 2'd1,
    RPT_MOUSE    = 2'd2
  } report_kind_e;

  localparam logic FUNC_RELEASE = 1'b1;

  typedef logic [BODY_LEN-1:0][7:0]  body_t;
  typedef logic [DEAD_KEYS-1:0][9:0] dead_codes_t;

  // One key event as held in the input register
  typedef struct packed {
    logic       func;
    logic [3:0] key_kind;
    logic [7:0] key_code;
    logic [7:0] move_y;
    logic       apply_mods;
  } key_event_t;

  // US layout for the lower half of the character range; upper half maps to 0
  localparam logic [9:0] US_LAYOUT [KEYMAP_ROWS] = '{
    10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
    10'h02a, 10'h02b, 10'h028, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
    10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
    10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
    10'h02c, SH|10'h1e, SH|10'h34, SH|10'h20, SH|10'h21, SH|10'h22, SH|10'h24, 10'h034,
    SH|10'h26, SH|10'h27, SH|10'h25, SH|10'h2e, 10'h036, 10'h02d, 10'h037, 10'h038,
    10'h027, 10'h01e, 10'h01f, 10'h020, 10'h021, 10'h022, 10'h023, 10'h024,
    10'h025, 10'h026, SH|10'h33, 10'h033, SH|10'h36, 10'h02e, SH|10'h37, SH|10'h38,
    SH|10'h1f, SH|10'h04, SH|10'h05, SH|10'h06, SH|10'h07, SH|10'h08, SH|10'h09, SH|10'h0a,
    SH|10'h0b, SH|10'h0c, SH|10'h0d, SH|10'h0e, SH|10'h0f, SH|10'h10, SH|10'h11, SH|10'h12,
    SH|10'h13, SH|10'h14, SH|10'h15, SH|10'h16, SH|10'h17, SH|10'h18, SH|10'h19, SH|10'h1a,
    SH|10'h1b, SH|10'h1c, SH|10'h1d, 10'h02f, 10'h031, 10'h030, SH|10'h23, SH|10'h2d,
    10'h035, 10'h004, 10'h005, 10'h006, 10'h007, 10'h008, 10'h009, 10'h00a,
    10'h00b, 10'h00c, 10'h00d, 10'h00e, 10'h00f, 10'h010, 10'h011, 10'h012,
    10'h013, 10'h014, 10'h015, 10'h016, 10'h017, 10'h018, 10'h019, 10'h01a,
    10'h01b, 10'h01c, 10'h01d, SH|10'h2f, SH|10'h31, SH|10'h30, SH|10'h35, 10'h000
  };

  function automatic logic [9:0] keymap_lookup(logic [7:0] code);
    logic [9:0] kc;
    kc = code[7] ? 10'h000 : US_LAYOUT[code[6:0]];
    return kc;
  endfunction

endpackage

>>> sv/hrb_cfg.sv
// Dead key code registers of the HID report builder.
// Depends on hrb_pkg for the register count and array type.
module hrb_cfg
  import hrb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  output dead_codes_t dead_codes_o
);

  dead_codes_t dead_q;

  assign cfg_ready_o  = 1'b1;
  assign dead_codes_o = dead_q;

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_q <= '0;
    end else if (cfg_valid_i && (32'(cfg_index_i) < DEAD_KEYS)) begin
      dead_q[cfg_index_i] <= cfg_data_i;
    end
  end

endmodule

>>> sv/hrb_core.sv
// Combinational report body update for one key event.
// Depends on hrb_pkg for event, body and keymap definitions.
module hrb_core
  import hrb_pkg::*;
(
  input  key_event_t   ev_i,
  input  body_t        body_i,
  input  dead_codes_t  dead_codes_i,
  output logic         emit_o,
  output report_kind_e kind_o,
  output body_t        body_o
);

  logic       rel;
  logic       key_path;
  logic       mods_ok;
  logic [9:0] kc;
  logic [7:0] low;
  logic [7:0] mods;
  logic [2:0] dead_idx;
  logic       dup;
  logic       placed;
  body_t      body_a;

  assign rel      = (ev_i.func == FUNC_RELEASE);
  assign dead_idx = 3'(ev_i.key_kind - KIND_DEAD_GRAVE);

  // Decode the event kind; mouse and media reports finish here
  always_comb begin
    body_a   = body_i;
    emit_o   = 1'b1;
    kind_o   = RPT_KEYBOARD;
    key_path = 1'b0;
    mods_ok  = 1'b0;
    kc       = '0;
    case (ev_i.key_kind)
      KIND_MEDIA: begin
        kind_o = RPT_MEDIA;
        body_a = '0;
        if (!rel) begin
          body_a[0] = ev_i.key_code;
        end
      end
      KIND_MBUTTON: begin
        kind_o = RPT_MOUSE;
        if (!rel) begin
          body_a = '0;
        end
        body_a[0] = rel ? 8'h00 : ev_i.key_code;
      end
      KIND_MWHEEL: begin
        kind_o = RPT_MOUSE;
        if (!rel) begin
          body_a = '0;
        end
        body_a[3] = rel ? 8'h00 : ev_i.key_code;
      end
      KIND_MMOVE: begin
        kind_o = RPT_MOUSE;
        if (!rel) begin
          body_a = '0;
        end
        body_a[1] = rel ? 8'h00 : ev_i.key_code;
        body_a[2] = rel ? 8'h00 : 8'(8'h00 - ev_i.move_y);
      end
      KIND_MODIFIER: begin
        key_path  = 1'b1;
        body_a[0] = rel ? (body_i[0] & ~ev_i.key_code) : (body_i[0] | ev_i.key_code);
      end
      KIND_SPECIAL: begin
        key_path = 1'b1;
        kc       = {2'b00, ev_i.key_code};
      end
      KIND_CHAR: begin
        key_path = 1'b1;
        mods_ok  = 1'b1;
        kc       = keymap_lookup(ev_i.key_code);
      end
      KIND_DEAD_GRAVE, KIND_DEAD_ACUTE, KIND_DEAD_CIRCUMFLEX,
      KIND_DEAD_TILDE, KIND_DEAD_DIAERESIS, KIND_DEAD_CEDILLA: begin
        key_path = 1'b1;
        mods_ok  = 1'b1;
        kc       = dead_codes_i[dead_idx];
      end
      default: begin
        emit_o = 1'b0;
      end
    endcase
  end

  assign low  = kc[7:0];
  assign mods = (kc[SHIFT_POS] ? MOD_LSHIFT : 8'h00) | (kc[ALTGR_POS] ? MOD_RALT : 8'h00);

  // Look for the code among the six slots
  always_comb begin
    dup = 1'b0;
    for (int i = 1; i < BODY_LEN; i++) begin
      if (body_a[i] == low) begin
        dup = 1'b1;
      end
    end
  end

  // Apply shift/AltGr, then place or clear the keycode in the slots
  always_comb begin
    body_o = body_a;
    placed = 1'b0;
    if (key_path) begin
      if (mods_ok && (rel || ev_i.apply_mods)) begin
        body_o[0] = rel ? (body_a[0] & ~mods) : (body_a[0] | mods);
      end
      if (low != 8'h00) begin
        for (int i = 1; i < BODY_LEN; i++) begin
          if (rel) begin
            if (body_a[i] == low) begin
              body_o[i] = 8'h00;
            end
          end else if (!dup && !placed && (body_a[i] == 8'h00)) begin
            body_o[i] = low;
            placed    = 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> sv/hid_report_builder_top.sv
// Top level of the HID report builder: input register, report body, result register.
// Depends on hrb_pkg, hrb_cfg and hrb_core.
//
// Takes one key event per clock while in_stall_o is low and returns at most one
// HID report per event (keyboard, media or mouse). An event sits in the input
// register, the shared 7-byte report body is updated from it by the combinational
// keymap lookup and the parallel six-slot compare, and the report lands in the
// result register, from which the result port presents it. The combinational
// body update is what lets back-to-back events run at one per clock while neither
// side stalls. Events of unknown kind are consumed without a report. The dead key
// codes are written through the configuration port, which is always ready and
// should only be used while no event is in flight.
module hid_report_builder_top
  import hrb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [3:0] key_kind_i,
  input  logic [7:0] key_code_i,
  input  logic [7:0] move_y_i,
  input  logic       apply_mods_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] report_kind_o,
  output logic [7:0] report_b1_o,
  output logic [7:0] report_b2_o,
  output logic [7:0] report_b3_o,
  output logic [7:0] report_b4_o,
  output logic [7:0] report_b5_o,
  output logic [7:0] report_b6_o,
  output logic [7:0] report_b7_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [9:0] cfg_data_i
);

  dead_codes_t  dead_codes;
  key_event_t   ev_q;
  logic         ev_valid_q;
  body_t        body_q;
  body_t        body_d;
  logic         emit;
  report_kind_e kind;
  logic         out_free;
  logic         proc;
  logic         out_valid_q;
  report_kind_e out_kind_q;
  body_t        out_body_q;

  hrb_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .dead_codes_o (dead_codes)
  );

  hrb_core u_core (
    .ev_i         (ev_q),
    .body_i       (body_q),
    .dead_codes_i (dead_codes),
    .emit_o       (emit),
    .kind_o       (kind),
    .body_o       (body_d)
  );

  // Process the held beat once its report has somewhere to go, or at once if it makes none
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = ev_valid_q && (!emit || out_free);
  assign in_stall_o = ev_valid_q && !proc;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      ev_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      ev_q <= '{func: func_i, key_kind: key_kind_i, key_code: key_code_i,
                move_y: move_y_i, apply_mods: apply_mods_i};
    end
  end

  // Report body state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_q <= '0;
    end else if (proc) begin
      body_q <= body_d;
    end
  end

  // Result register: load a new report, drop a delivered one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      out_kind_q <= kind;
      out_body_q <= body_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign report_kind_o = out_kind_q;
  assign report_b1_o   = out_body_q[0];
  assign report_b2_o   = out_body_q[1];
  assign report_b3_o   = out_body_q[2];
  assign report_b4_o   = out_body_q[3];
  assign report_b5_o   = out_body_q[4];
  assign report_b6_o   = out_body_q[5];
  assign report_b7_o   = out_body_q[6];

`ifndef SYNTHESIS
  // The input side only stalls while an event is held
  a_stall_needs_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ev_valid_q)
    else $error("input stalled with no event held");

  // The body only changes when an event is processed
  a_body_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc |=> $stable(body_q))
    else $error("report body changed without an event");

  // A media report carries nothing past its first byte
  a_media_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (report_kind_o == RPT_MEDIA)) |->
      ((report_b2_o == 8'h00) && (report_b3_o == 8'h00) && (report_b4_o == 8'h00) &&
       (report_b5_o == 8'h00) && (report_b6_o == 8'h00) && (report_b7_o == 8'h00)))
    else $error("media report with non-zero trailing bytes");
`endif

endmodule

>>> sim/hid_report_builder_checker.sv
// Scoreboard for the HID report builder: predicts each report from the key events
// accepted on the input channel and compares it with the report beats delivered.
// Depends on hrb_pkg for the event struct, key kinds and report kinds.
module hid_report_builder_checker
  import hrb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       func_i,
  input  logic [3:0] key_kind_i,
  input  logic [7:0] key_code_i,
  input  logic [7:0] move_y_i,
  input  logic       apply_mods_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] report_kind_i,
  input  logic [7:0] report_b1_i,
  input  logic [7:0] report_b2_i,
  input  logic [7:0] report_b3_i,
  input  logic [7:0] report_b4_i,
  input  logic [7:0] report_b5_i,
  input  logic [7:0] report_b6_i,
  input  logic [7:0] report_b7_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [2:0] cfg_index_i,
  input  logic [9:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Keycode flag bits and the modifier bits they drive
  localparam logic [9:0] SF         = 10'h100;
  localparam logic [9:0] ALTGR_FLAG = 10'h200;
  localparam logic [7:0] LSHIFT_MOD = 8'h02;
  localparam logic [7:0] RALT_MOD   = 8'h40;

  // US layout for characters 0..127; anything above looks up as zero
  localparam logic [9:0] US_CHAR_CODES [128] = '{
    10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
    10'h02a, 10'h02b, 10'h028, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
    10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
    10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
    10'h02c, SF|10'h1e, SF|10'h34, SF|10'h20, SF|10'h21, SF|10'h22, SF|10'h24, 10'h034,
    SF|10'h26, SF|10'h27, SF|10'h25, SF|10'h2e, 10'h036, 10'h02d, 10'h037, 10'h038,
    10'h027, 10'h01e, 10'h01f, 10'h020, 10'h021, 10'h022, 10'h023, 10'h024,
    10'h025, 10'h026, SF|10'h33, 10'h033, SF|10'h36, 10'h02e, SF|10'h37, SF|10'h38,
    SF|10'h1f, SF|10'h04, SF|10'h05, SF|10'h06, SF|10'h07, SF|10'h08, SF|10'h09, SF|10'h0a,
    SF|10'h0b, SF|10'h0c, SF|10'h0d, SF|10'h0e, SF|10'h0f, SF|10'h10, SF|10'h11, SF|10'h12,
    SF|10'h13, SF|10'h14, SF|10'h15, SF|10'h16, SF|10'h17, SF|10'h18, SF|10'h19, SF|10'h1a,
    SF|10'h1b, SF|10'h1c, SF|10'h1d, 10'h02f, 10'h031, 10'h030, SF|10'h23, SF|10'h2d,
    10'h035, 10'h004, 10'h005, 10'h006, 10'h007, 10'h008, 10'h009, 10'h00a,
    10'h00b, 10'h00c, 10'h00d, 10'h00e, 10'h00f, 10'h010, 10'h011, 10'h012,
    10'h013, 10'h014, 10'h015, 10'h016, 10'h017, 10'h018, 10'h019, 10'h01a,
    10'h01b, 10'h01c, 10'h01d, SF|10'h2f, SF|10'h31, SF|10'h30, SF|10'h35, 10'h000
  };

  typedef struct packed {
    report_kind_e                 kind;
    logic [BODY_LEN-1:0][7:0]     bytes;
  } hid_report_t;

  logic [7:0]  key_body [BODY_LEN];
  logic [9:0]  dead_code [DEAD_KEYS];
  hid_report_t expected_reports [$];
  int          fail_count = 0;
  int          pending_count = 0;
  int          report_no;
  key_event_t  in_event;
  logic [7:0]  got_bytes [BODY_LEN];

  assign in_event = {func_i, key_kind_i, key_code_i, move_y_i, apply_mods_i};
  assign got_bytes[0] = report_b1_i;
  assign got_bytes[1] = report_b2_i;
  assign got_bytes[2] = report_b3_i;
  assign got_bytes[3] = report_b4_i;
  assign got_bytes[4] = report_b5_i;
  assign got_bytes[5] = report_b6_i;
  assign got_bytes[6] = report_b7_i;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_count;

  task automatic flag_error(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [9:0] char_keycode(input logic [7:0] ch);
    return ch[7] ? 10'h000 : US_CHAR_CODES[ch[6:0]];
  endfunction

  // Advance the report body by one key event; return 0 when the event yields no report
  function automatic bit build_report(input key_event_t ev, output hid_report_t rpt);
    logic [9:0] kc;
    logic       mods_ok;
    logic       key_up;
    logic [7:0] low;
    logic [7:0] mods;
    logic       dup;
    kc      = '0;
    mods_ok = 1'b0;
    key_up  = (ev.func == FUNC_RELEASE);
    rpt     = '0;
    case (ev.key_kind)
      KIND_MEDIA: begin
        foreach (key_body[i]) key_body[i] = 8'h00;
        if (!key_up) key_body[0] = ev.key_code;
        rpt.kind = RPT_MEDIA;
      end
      KIND_MBUTTON, KIND_MWHEEL, KIND_MMOVE: begin
        // a press starts from an empty body, a release only clears its own bytes
        if (!key_up) begin
          foreach (key_body[i]) key_body[i] = 8'h00;
        end
        if (ev.key_kind == KIND_MBUTTON) begin
          key_body[0] = key_up ? 8'h00 : ev.key_code;
        end else if (ev.key_kind == KIND_MMOVE) begin
          key_body[1] = key_up ? 8'h00 : ev.key_code;
          key_body[2] = key_up ? 8'h00 : 8'h00 - ev.move_y;
        end else begin
          key_body[3] = key_up ? 8'h00 : ev.key_code;
        end
        rpt.kind = RPT_MOUSE;
      end
      default: begin
        case (ev.key_kind)
          KIND_MODIFIER: begin
            key_body[0] = key_up ? (key_body[0] & ~ev.key_code) : (key_body[0] | ev.key_code);
          end
          KIND_SPECIAL: kc = {2'b00, ev.key_code};
          KIND_CHAR: begin
            kc      = char_keycode(ev.key_code);
            mods_ok = 1'b1;
          end
          KIND_DEAD_GRAVE, KIND_DEAD_ACUTE, KIND_DEAD_CIRCUMFLEX,
          KIND_DEAD_TILDE, KIND_DEAD_DIAERESIS, KIND_DEAD_CEDILLA: begin
            kc      = dead_code[ev.key_kind - KIND_DEAD_GRAVE];
            mods_ok = 1'b1;
          end
          default: return 1'b0;
        endcase

        // char and dead key flags: set on a press with mods, always cleared on release
        if (mods_ok && (key_up || ev.apply_mods)) begin
          mods = 8'h00;
          if ((kc & SF) != 0) mods = mods | LSHIFT_MOD;
          if ((kc & ALTGR_FLAG) != 0) mods = mods | RALT_MOD;
          key_body[0] = key_up ? (key_body[0] & ~mods) : (key_body[0] | mods);
        end

        // six key slots: release clears every match, press fills the first free one
        low = kc[7:0];
        if (low != 8'h00) begin
          if (key_up) begin
            for (int i = 1; i <= KEY_SLOTS; i++)
              if (key_body[i] == low) key_body[i] = 8'h00;
          end else begin
            dup = 1'b0;
            for (int i = 1; i <= KEY_SLOTS; i++)
              if (key_body[i] == low) dup = 1'b1;
            for (int i = 1; i <= KEY_SLOTS; i++) begin
              if (!dup && key_body[i] == 8'h00) begin
                key_body[i] = low;
                dup = 1'b1;
              end
            end
          end
        end
        rpt.kind = RPT_KEYBOARD;
      end
    endcase
    foreach (key_body[i]) rpt.bytes[i] = key_body[i];
    return 1'b1;
  endfunction

  // Check result beats before taking new events: a result always belongs to older events
  always @(posedge clk_i or negedge rst_ni) begin
    hid_report_t want;
    hid_report_t made;
    if (!rst_ni) begin
      foreach (key_body[i]) key_body[i] = 8'h00;
      foreach (dead_code[i]) dead_code[i] = 10'h000;
      expected_reports.delete();
      report_no     = 0;
      pending_count = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        report_no++;
        if (expected_reports.size() == 0) begin
          flag_error($sformatf("report %0d: kind %0d arrived with none outstanding",
                               report_no, report_kind_i));
        end else begin
          want = expected_reports.pop_front();
          if (report_kind_i !== want.kind)
            flag_error($sformatf("report %0d: report_kind got %0d, want %0d",
                                 report_no, report_kind_i, want.kind));
          foreach (got_bytes[i])
            if (got_bytes[i] !== want.bytes[i])
              flag_error($sformatf("report %0d: report_b%0d got %h, want %h",
                                   report_no, i + 1, got_bytes[i], want.bytes[i]));
        end
      end
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < DEAD_KEYS)
        dead_code[cfg_index_i] = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (build_report(in_event, made)) expected_reports.push_back(made);
      end
      pending_count = expected_reports.size();
    end
  end

endmodule

>>> sim/hid_report_builder_top_tb.sv
// Testbench top for the HID report builder: clock, reset, key event and dead key
// stimulus, output back-pressure and the verdict. Depends on hrb_pkg, the block
// and hid_report_builder_checker, which does all prediction and comparison.
module hid_report_builder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrb_pkg::*;

  localparam int   CLK_HALF        = 4;
  localparam int   RESET_CYCLES    = 10;
  localparam int   WATCHDOG_LIMIT  = 3000;
  localparam int   HOLD_OFF_CYCLES = 200;
  localparam int   SETTLE_CYCLES   = 6;
  localparam int   RANDOM_PHASES   = 8;
  localparam int   PHASE_ITEMS     = 215;
  localparam logic FUNC_PRESS      = 1'b0;
  localparam logic [3:0] KIND_UNKNOWN_LO = 4'd13;
  localparam logic [3:0] KIND_UNKNOWN_HI = 4'd15;

  // Dead key codes with a mix of AltGr, shift, both, a zero keycode and all ones
  localparam logic [9:0] ACCENT_CODES [DEAD_KEYS] = '{
    10'h235, 10'h134, 10'h123, 10'h335, 10'h300, 10'h3ff
  };
  // Characters that hit often so that presses and releases meet
  localparam int         CHAR_POOL_LEN = 10;
  localparam logic [7:0] CHAR_POOL [CHAR_POOL_LEN] = '{
    8'h61, 8'h41, 8'h62, 8'h42, 8'h31, 8'h21, 8'h20, 8'h7e, 8'h60, 8'h0a
  };

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum int {CODES_ACCENTS, CODES_ALL_ONES, CODES_ZERO, CODES_RANDOM} dead_set_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       func_i;
  logic [3:0] key_kind_i;
  logic [7:0] key_code_i;
  logic [7:0] move_y_i;
  logic       apply_mods_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] report_kind_o;
  logic [7:0] report_b1_o;
  logic [7:0] report_b2_o;
  logic [7:0] report_b3_o;
  logic [7:0] report_b4_o;
  logic [7:0] report_b5_o;
  logic [7:0] report_b6_o;
  logic [7:0] report_b7_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [9:0] cfg_data_i;

  int   fail_count;
  int   pending_reports;
  int   tx_idle_pct;
  int   rx_stall_pct;
  bit   hold_off_req;
  logic beat_seen;

  hid_report_builder_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .key_kind_i    (key_kind_i),
    .key_code_i    (key_code_i),
    .move_y_i      (move_y_i),
    .apply_mods_i  (apply_mods_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .report_kind_o (report_kind_o),
    .report_b1_o   (report_b1_o),
    .report_b2_o   (report_b2_o),
    .report_b3_o   (report_b3_o),
    .report_b4_o   (report_b4_o),
    .report_b5_o   (report_b5_o),
    .report_b6_o   (report_b6_o),
    .report_b7_o   (report_b7_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  hid_report_builder_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .func_i        (func_i),
    .key_kind_i    (key_kind_i),
    .key_code_i    (key_code_i),
    .move_y_i      (move_y_i),
    .apply_mods_i  (apply_mods_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .report_kind_i (report_kind_o),
    .report_b1_i   (report_b1_o),
    .report_b2_i   (report_b2_o),
    .report_b3_i   (report_b3_o),
    .report_b4_i   (report_b4_o),
    .report_b5_i   (report_b5_o),
    .report_b6_i   (report_b6_o),
    .report_b7_i   (report_b7_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending_reports)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Receiver: random stall, or a long hold-off when asked for one
  initial begin
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Watchdog: end the run once nothing has moved on any channel for too long
  assign beat_seen = (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                     (cfg_valid_i && cfg_ready_o);

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (beat_seen) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic key_event_t key_event(input logic f, input logic [3:0] k,
                                           input logic [7:0] c, input logic [7:0] y,
                                           input logic a);
    key_event_t ev;
    ev.func       = f;
    ev.key_kind   = k;
    ev.key_code   = c;
    ev.move_y     = y;
    ev.apply_mods = a;
    return ev;
  endfunction

  // Mostly keyboard traffic on a small key set so slots fill, repeat and clear
  function automatic key_event_t random_key_event();
    key_event_t  ev;
    int unsigned pick;
    ev.func       = ($urandom_range(99) < 35) ? FUNC_RELEASE : FUNC_PRESS;
    ev.key_code   = 8'($urandom_range(255));
    ev.move_y     = 8'($urandom_range(255));
    ev.apply_mods = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 42) begin
      ev.key_kind = KIND_CHAR;
      if ($urandom_range(99) < 65) ev.key_code = CHAR_POOL[$urandom_range(CHAR_POOL_LEN - 1)];
    end else if (pick < 58) begin
      ev.key_kind = KIND_SPECIAL;
      if ($urandom_range(99) < 65) ev.key_code = 8'h04 + 8'($urandom_range(7));
    end else if (pick < 67) begin
      ev.key_kind = KIND_MODIFIER;
    end else if (pick < 71) begin
      ev.key_kind = KIND_MEDIA;
    end else if (pick < 79) begin
      ev.key_kind = 4'(KIND_MBUTTON + $urandom_range(2));
    end else if (pick < 95) begin
      ev.key_kind = 4'(KIND_DEAD_GRAVE + $urandom_range(5));
    end else begin
      ev.key_kind = 4'(KIND_UNKNOWN_LO + $urandom_range(KIND_UNKNOWN_HI - KIND_UNKNOWN_LO));
    end
    return ev;
  endfunction

  function automatic logic [9:0] dead_code_for(input dead_set_e sel, input int r);
    case (sel)
      CODES_ACCENTS:  return ACCENT_CODES[r];
      CODES_ALL_ONES: return 10'h3ff;
      CODES_ZERO:     return 10'h000;
      default:        return 10'($urandom_range(1023));
    endcase
  endfunction

  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      IDLE_SENDER:   begin tx_idle_pct = 88; rx_stall_pct = 0;  end
      IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
      default:       begin tx_idle_pct = 13; rx_stall_pct = 13; end
    endcase
  endtask

  // Write every dead key register; valid stays high across back-to-back beats
  task automatic program_dead_codes(input dead_set_e sel);
    for (int r = 0; r < DEAD_KEYS; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 3'(r);
      cfg_data_i  <= dead_code_for(sel, r);
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one event after a random gap and hold it until the block takes it
  task automatic push_event(input key_event_t ev);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= ev.func;
    key_kind_i   <= ev.key_kind;
    key_code_i   <= ev.key_code;
    move_y_i     <= ev.move_y;
    apply_mods_i <= ev.apply_mods;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every predicted report has come back
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    while (pending_reports != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_directed();
    // null code, character above the layout, shifted character and its repeat
    push_event(key_event(FUNC_PRESS, KIND_CHAR, 8'h00, 8'h00, 1'b1));
    push_event(key_event(FUNC_PRESS, KIND_CHAR, 8'hff, 8'hff, 1'b1));
    push_event(key_event(FUNC_PRESS, KIND_CHAR, 8'h41, 8'h00, 1'b1));
    push_event(key_event(FUNC_PRESS, KIND_CHAR, 8'h41, 8'h00, 1'b1));
    // fill the remaining slots, then press into a full report
    for (int c = 8'h10; c <= 8'h14; c++)
      push_event(key_event(FUNC_PRESS, KIND_SPECIAL, 8'(c), 8'h00, 1'b0));
    push_event(key_event(FUNC_PRESS, KIND_SPECIAL, 8'h15, 8'h00, 1'b0));
    push_event(key_event(FUNC_PRESS, KIND_DEAD_GRAVE, 8'h00, 8'h00, 1'b1));
    // modifiers, releases with and without mods, release of a null code
    push_event(key_event(FUNC_PRESS, KIND_MODIFIER, 8'hff, 8'h00, 1'b0));
    push_event(key_event(FUNC_RELEASE, KIND_MODIFIER, 8'h0f, 8'h00, 1'b0));
    push_event(key_event(FUNC_RELEASE, KIND_SPECIAL, 8'h12, 8'h00, 1'b0));
    push_event(key_event(FUNC_RELEASE, KIND_CHAR, 8'h41, 8'h00, 1'b0));
    push_event(key_event(FUNC_RELEASE, KIND_SPECIAL, 8'h00, 8'h00, 1'b0));
    // media and mouse presses clear the body, mouse releases keep the rest
    push_event(key_event(FUNC_PRESS, KIND_MEDIA, 8'he9, 8'h00, 1'b0));
    push_event(key_event(FUNC_RELEASE, KIND_MEDIA, 8'he9, 8'h00, 1'b0));
    push_event(key_event(FUNC_PRESS, KIND_MBUTTON, 8'h05, 8'h00, 1'b0));
    push_event(key_event(FUNC_PRESS, KIND_MMOVE, 8'h7f, 8'h80, 1'b0));
    push_event(key_event(FUNC_PRESS, KIND_MWHEEL, 8'hff, 8'h01, 1'b1));
    push_event(key_event(FUNC_RELEASE, KIND_MBUTTON, 8'h05, 8'h00, 1'b0));
    push_event(key_event(FUNC_RELEASE, KIND_MMOVE, 8'h7f, 8'hff, 1'b0));
    // unknown kinds yield nothing
    push_event(key_event(FUNC_PRESS, KIND_UNKNOWN_LO, 8'h55, 8'haa, 1'b1));
    push_event(key_event(FUNC_RELEASE, KIND_UNKNOWN_HI, 8'haa, 8'h55, 1'b0));
    push_event(key_event(FUNC_PRESS, KIND_DEAD_CEDILLA, 8'h00, 8'h00, 1'b1));
  endtask

  // Random events; ignored kinds do not count towards the phase length
  task automatic run_random(input int items, input bit with_hold_off);
    key_event_t ev;
    int         sent;
    bit         held;
    sent = 0;
    held = 1'b0;
    while (sent < items) begin
      if (with_hold_off && !held && sent == items / 2) begin
        hold_off_req = 1'b1;
        held         = 1'b1;
      end
      ev = random_key_event();
      push_event(ev);
      if (ev.key_kind < KIND_UNKNOWN_LO) sent++;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = 1'b0;
    key_kind_i   = 4'h0;
    key_code_i   = 8'h00;
    move_y_i     = 8'h00;
    apply_mods_i = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = 3'h0;
    cfg_data_i   = 10'h000;
    hold_off_req = 1'b0;
    set_idle_mode(IDLE_NONE);
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    program_dead_codes(CODES_ACCENTS);
    run_directed();
    drain_reports();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_idle_mode(idle_mode_e'(p % 4));
      program_dead_codes(dead_set_e'((p * 3) % 4));
      run_random(PHASE_ITEMS, (p % 4) == 0);
      drain_reports();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
